### rtl/ssac_pkg.sv
// Shared types, constants and helper functions for the serial scheduled alarm clock.
// Used by ssac_ctrl, ssac_datapath and serial_scheduled_alarm_clock_unit; no dependencies.
package ssac_pkg;

	localparam int ALARM_ENTRIES_DEFAULT = 5;

	// Command buffer: command letter plus up to six digits.
	localparam int BUF_DEPTH = 7;
	localparam int FILL_W = $clog2(BUF_DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_TIME = FILL_W'(BUF_DEPTH);
	localparam logic [FILL_W-1:0] FILL_ENTRY = FILL_W'(6);
	localparam logic [FILL_W-1:0] FILL_COUNT = FILL_W'(2);

	localparam logic [7:0] TPS_RESET = 8'd20;
	localparam logic [7:0] SECONDS_PER_MINUTE = 8'd60;
	localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;
	localparam logic [7:0] HOURS_PER_DAY = 8'd24;
	localparam int ACTIVE_RESET = 3;

	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] CHAR_T_UPPER = 8'h54;
	localparam logic [7:0] CHAR_T_LOWER = 8'h74;
	localparam logic [7:0] CHAR_F_UPPER = 8'h46;
	localparam logic [7:0] CHAR_F_LOWER = 8'h66;
	localparam logic [7:0] CHAR_C_UPPER = 8'h43;
	localparam logic [7:0] CHAR_C_LOWER = 8'h63;
	localparam logic [7:0] CHAR_M_UPPER = 8'h4D;
	localparam logic [7:0] CHAR_M_LOWER = 8'h6D;
	localparam logic [7:0] CHAR_S_UPPER = 8'h53;
	localparam logic [7:0] CHAR_S_LOWER = 8'h73;

	typedef enum logic [2:0] {
		KIND_AUTO_FEED    = 3'd0,
		KIND_MANUAL_FEED  = 3'd1,
		KIND_TIME_SET     = 3'd2,
		KIND_ENTRY_SET    = 3'd3,
		KIND_COUNT_SET    = 3'd4,
		KIND_STATUS_HEAD  = 3'd5,
		KIND_STATUS_ENTRY = 3'd6
	} kind_t;

	// Operations the controller asks of the datapath.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_TICK,
		OP_BYTE,
		OP_CHECK,
		OP_MASK,
		OP_FEED,
		OP_ENTRY
	} op_t;

	typedef struct packed {
		logic is_tick;
		logic roll;
		logic is_status;
		logic will_append;
		logic scan_empty;
		logic scan_end;
	} dp_status_t;

	// Two ASCII digits to a value, wrapping modulo 256 without any digit check.
	function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] d;
		d = hi - DIGIT_ZERO;
		return 8'((d << 3) + (d << 1) + (lo - DIGIT_ZERO));
	endfunction

	function automatic logic [7:0] alarm_hour_reset(input int i);
		case (i)
			0: return 8'd8;
			1: return 8'd13;
			2: return 8'd20;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] alarm_minute_reset(input int i);
		case (i)
			1: return 8'd30;
			default: return 8'd0;
		endcase
	endfunction

endpackage

### rtl/serial_scheduled_alarm_clock_unit.sv
// Top level of the serial scheduled alarm clock: controller and datapath joined together.
// Depends on ssac_pkg, ssac_ctrl and ssac_datapath.
//
// Usage. A transaction is offered on cmd and rx_byte with start; it is taken at a rising edge
// at which start is high and busy is low. cmd low is one timer tick, cmd high is one received
// serial byte. Results leave one at a time on kind, entry_index, out_hour, out_minute,
// out_second and already_passed, each valid for exactly one cycle while strobe is high, and
// last marks the final result of a transaction. A transaction may give no result at all.
// The receiver cannot stall the block, so results are never held back.
//
// Timing. A transaction is accepted in the idle state and carried out in the execute state;
// busy then falls and the next one can be taken. A byte that extends an open command adds a
// check state, a status request adds one entry step per alarm entry in use, and a tick that
// completes a minute adds a mask step and then one feed step per entry in use. The walk over
// the alarm table, one entry per cycle, sets the longest case. Each result is registered and
// appears in the cycle after the cycle that forms it.
//
// Write the ticks-per-second register (cfg_wr_en, cfg_wr_data) only while the block is idle; the
// block does not enforce this. Reset loads the register's default, clears the time, marks the clock
// unset and restores the default alarm table with three entries active; the block is ready at once.
module serial_scheduled_alarm_clock_unit #(
	parameter int ALARM_ENTRIES = ssac_pkg::ALARM_ENTRIES_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output logic       strobe,
	output logic [2:0] kind,
	output logic [2:0] entry_index,
	output logic [7:0] out_hour,
	output logic [7:0] out_minute,
	output logic [7:0] out_second,
	output logic       already_passed,
	output logic       last
);
	import ssac_pkg::*;

	op_t        op;
	dp_status_t sts;

	// The controller decides which operation the datapath performs in each cycle.
	ssac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.op     (op),
		.busy   (busy)
	);

	// The datapath holds all clock and table state and registers every result.
	ssac_datapath #(
		.ALARM_ENTRIES (ALARM_ENTRIES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.sts            (sts),
		.cmd            (cmd),
		.rx_byte        (rx_byte),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.strobe         (strobe),
		.kind           (kind),
		.entry_index    (entry_index),
		.out_hour       (out_hour),
		.out_minute     (out_minute),
		.out_second     (out_second),
		.already_passed (already_passed),
		.last           (last)
	);

	// An accepted transaction always occupies the block in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted transaction did not make the block busy");

	// A result that is not the final one means the controller is still walking the transaction.
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && !last) |-> busy)
		else $error("intermediate result shown while the block is idle");

	// After the final result no other result can follow in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && last) |=> !strobe)
		else $error("result directly after the final result of a transaction");

	// Only a status entry carries the already-passed flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (kind != KIND_STATUS_ENTRY)) |-> !already_passed)
		else $error("already_passed set on a result that is not a status entry");

endmodule

### rtl/ssac_ctrl.sv
// Controller state machine of the alarm clock: sequences each transaction through the datapath.
// Depends on ssac_pkg for the operation codes and the datapath status struct.
module ssac_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ssac_pkg::dp_status_t sts,
	output ssac_pkg::op_t        op,
	output logic                 busy
);
	import ssac_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_MASK,
		ST_FEED,
		ST_ENTRIES
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		op = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op = OP_ACCEPT;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_tick) begin
					op = OP_TICK;
					state_d = (sts.roll && !sts.scan_empty) ? ST_MASK : ST_IDLE;
				end else begin
					op = OP_BYTE;
					if (sts.is_status && !sts.scan_empty) begin
						state_d = ST_ENTRIES;
					end else if (sts.will_append) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CHECK: begin
				op = OP_CHECK;
				state_d = ST_IDLE;
			end
			ST_MASK: begin
				op = OP_MASK;
				state_d = ST_FEED;
			end
			ST_FEED: begin
				op = OP_FEED;
				if (sts.scan_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_ENTRIES: begin
				op = OP_ENTRY;
				if (sts.scan_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

### rtl/ssac_datapath.sv
// Datapath of the alarm clock: time of day, prescaler, command buffer, alarm table and result registers.
// Depends on ssac_pkg; driven by operations from ssac_ctrl.
module ssac_datapath #(
	parameter int ALARM_ENTRIES = ssac_pkg::ALARM_ENTRIES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssac_pkg::op_t        op,
	output ssac_pkg::dp_status_t sts,
	input  logic                 cmd,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data,
	output logic                 strobe,
	output logic [2:0]           kind,
	output logic [2:0]           entry_index,
	output logic [7:0]           out_hour,
	output logic [7:0]           out_minute,
	output logic [7:0]           out_second,
	output logic                 already_passed,
	output logic                 last
);
	import ssac_pkg::*;

	localparam int IDX_W = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;
	localparam int CNT_W = ($clog2(ALARM_ENTRIES + 1) > 2) ? $clog2(ALARM_ENTRIES + 1) : 2;
	localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ALARM_ENTRIES);
	localparam logic [7:0] ENTRIES_B = 8'(ALARM_ENTRIES);

	logic                     item_cmd_q;
	logic [7:0]               item_byte_q;
	logic [7:0]               tps_q;
	logic [7:0]               hour_q;
	logic [7:0]               minute_q;
	logic [7:0]               second_q;
	logic [7:0]               prescale_q;
	logic                     valid_q;
	logic [7:0]               buf_q [BUF_DEPTH];
	logic [FILL_W-1:0]        fill_q;
	logic [7:0]               alarm_hour_q [ALARM_ENTRIES];
	logic [7:0]               alarm_minute_q [ALARM_ENTRIES];
	logic [CNT_W-1:0]         active_q;
	logic [ALARM_ENTRIES-1:0] mask_q;
	logic [IDX_W-1:0]         idx_q;

	logic                     strobe_q;
	kind_t                    kind_q;
	logic [2:0]               index_q;
	logic [7:0]               hour_out_q;
	logic [7:0]               minute_out_q;
	logic [7:0]               second_out_q;
	logic                     passed_q;
	logic                     last_q;

	logic [CNT_W-1:0]         in_use;
	logic [7:0]               pre_inc;
	logic [7:0]               sec_inc;
	logic [7:0]               min_inc;
	logic [7:0]               hr_inc;
	logic [7:0]               hr_next;
	logic                     is_t, is_f, is_c, is_m, is_s;
	logic                     head_t, head_f, head_c;
	logic                     done_t, done_f, done_c;
	logic                     do_restart;
	logic                     will_append;
	logic [7:0]               num;
	logic                     num_ok;
	logic [IDX_W-1:0]         ent_sel;
	logic [7:0]               ld_hour, ld_minute, ld_second;
	logic [7:0]               ent_hour, ent_minute;
	logic [ALARM_ENTRIES-1:0] mask_d;
	logic                     rest_any;
	logic                     scan_end;
	logic [7:0]               cur_hour, cur_minute;
	logic                     cur_passed;
	logic [3:0]               idx_num;
	logic [3:0]               act_num;

	logic                     emit;
	kind_t                    e_kind;
	logic [2:0]               e_index;
	logic [7:0]               e_hour, e_minute, e_second;
	logic                     e_passed;
	logic                     e_last;

	assign in_use = (active_q < ENTRIES_C) ? active_q : ENTRIES_C;

	// Time of day arithmetic for one tick.
	assign pre_inc = prescale_q + 8'd1;
	assign sec_inc = second_q + 8'd1;
	assign min_inc = minute_q + 8'd1;
	assign hr_inc  = hour_q + 8'd1;
	assign hr_next = (hr_inc >= HOURS_PER_DAY) ? 8'd0 : hr_inc;

	// Classes of the received byte and of the buffered command letter.
	assign is_t = (item_byte_q == CHAR_T_UPPER) || (item_byte_q == CHAR_T_LOWER);
	assign is_f = (item_byte_q == CHAR_F_UPPER) || (item_byte_q == CHAR_F_LOWER);
	assign is_c = (item_byte_q == CHAR_C_UPPER) || (item_byte_q == CHAR_C_LOWER);
	assign is_m = (item_byte_q == CHAR_M_UPPER) || (item_byte_q == CHAR_M_LOWER);
	assign is_s = (item_byte_q == CHAR_S_UPPER) || (item_byte_q == CHAR_S_LOWER);

	assign head_t = (buf_q[0] == CHAR_T_UPPER) || (buf_q[0] == CHAR_T_LOWER);
	assign head_f = (buf_q[0] == CHAR_F_UPPER) || (buf_q[0] == CHAR_F_LOWER);
	assign head_c = (buf_q[0] == CHAR_C_UPPER) || (buf_q[0] == CHAR_C_LOWER);

	assign done_t = head_t && (fill_q == FILL_TIME);
	assign done_f = head_f && (fill_q == FILL_ENTRY);
	assign done_c = head_c && (fill_q == FILL_COUNT);

	// Before the clock is set only a time command opens the buffer.
	assign do_restart = valid_q ? (is_t || is_f || is_c) : is_t;
	assign will_append = item_cmd_q && (fill_q != '0) && !do_restart
		&& !(valid_q && (is_m || is_s));

	assign num     = buf_q[1] - DIGIT_ZERO;
	assign num_ok  = (num >= 8'd1) && (num <= ENTRIES_B);
	assign ent_sel = IDX_W'(num - 8'd1);

	assign ld_hour    = two_digits(buf_q[1], buf_q[2]);
	assign ld_minute  = two_digits(buf_q[3], buf_q[4]);
	assign ld_second  = two_digits(buf_q[5], buf_q[6]);
	assign ent_hour   = two_digits(buf_q[2], buf_q[3]);
	assign ent_minute = two_digits(buf_q[4], buf_q[5]);

	always_comb begin
		for (int i = 0; i < ALARM_ENTRIES; i++) begin
			mask_d[i] = (CNT_W'(i) < in_use) && (hour_q == alarm_hour_q[i])
				&& (minute_q == alarm_minute_q[i]);
		end
	end

	// Is there a further matching entry after the current scan position?
	always_comb begin
		rest_any = 1'b0;
		for (int j = 0; j < ALARM_ENTRIES; j++) begin
			if ((j > int'(idx_q)) && mask_q[j]) begin
				rest_any = 1'b1;
			end
		end
	end

	assign scan_end   = ((5'(idx_q) + 5'd1) >= 5'(in_use));
	assign cur_hour   = alarm_hour_q[idx_q];
	assign cur_minute = alarm_minute_q[idx_q];
	assign cur_passed = (hour_q > cur_hour) || ((hour_q == cur_hour) && (minute_q >= cur_minute));
	assign idx_num    = 4'(idx_q) + 4'd1;
	assign act_num    = 4'(active_q);

	always_comb begin
		sts.is_tick     = !item_cmd_q;
		sts.roll        = valid_q && !(pre_inc < tps_q) && !(sec_inc < SECONDS_PER_MINUTE);
		sts.is_status   = item_cmd_q && valid_q && is_s;
		sts.will_append = will_append;
		sts.scan_empty  = (in_use == '0);
		sts.scan_end    = scan_end;
	end

	always_comb begin
		emit = 1'b0;
		e_kind = KIND_AUTO_FEED;
		e_index = 3'd0;
		e_hour = hour_q;
		e_minute = minute_q;
		e_second = second_q;
		e_passed = 1'b0;
		e_last = 1'b1;
		case (op)
			OP_FEED: begin
				emit = mask_q[idx_q];
				e_index = idx_num[2:0];
				e_last = !rest_any;
			end
			OP_BYTE: begin
				if (valid_q && is_m) begin
					emit = 1'b1;
					e_kind = KIND_MANUAL_FEED;
				end else if (valid_q && is_s) begin
					emit = 1'b1;
					e_kind = KIND_STATUS_HEAD;
					e_index = act_num[2:0];
					e_last = (in_use == '0);
				end
			end
			OP_CHECK: begin
				if (done_t) begin
					emit = 1'b1;
					e_kind = KIND_TIME_SET;
					e_hour = ld_hour;
					e_minute = ld_minute;
					e_second = ld_second;
				end else if (done_f && num_ok) begin
					emit = 1'b1;
					e_kind = KIND_ENTRY_SET;
					e_index = num[2:0];
					e_hour = ent_hour;
					e_minute = ent_minute;
					e_second = 8'd0;
				end else if (done_c && num_ok) begin
					emit = 1'b1;
					e_kind = KIND_COUNT_SET;
					e_index = num[2:0];
					e_hour = 8'd0;
					e_minute = 8'd0;
					e_second = 8'd0;
				end
			end
			OP_ENTRY: begin
				emit = 1'b1;
				e_kind = KIND_STATUS_ENTRY;
				e_index = idx_num[2:0];
				e_hour = cur_hour;
				e_minute = cur_minute;
				e_second = 8'd0;
				e_passed = cur_passed;
				e_last = scan_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			hour_q <= 8'd0;
			minute_q <= 8'd0;
			second_q <= 8'd0;
			prescale_q <= 8'd0;
			valid_q <= 1'b0;
			fill_q <= '0;
			for (int i = 0; i < ALARM_ENTRIES; i++) begin
				alarm_hour_q[i] <= alarm_hour_reset(i);
				alarm_minute_q[i] <= alarm_minute_reset(i);
			end
			active_q <= CNT_W'(ACTIVE_RESET);
			idx_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (cfg_wr_en) begin
				tps_q <= cfg_wr_data;
			end
			case (op)
				OP_TICK: begin
					if (valid_q) begin
						if (pre_inc < tps_q) begin
							prescale_q <= pre_inc;
						end else begin
							prescale_q <= 8'd0;
							if (sec_inc < SECONDS_PER_MINUTE) begin
								second_q <= sec_inc;
							end else begin
								second_q <= 8'd0;
								if (min_inc < MINUTES_PER_HOUR) begin
									minute_q <= min_inc;
								end else begin
									minute_q <= 8'd0;
									hour_q <= hr_next;
								end
							end
						end
					end
				end
				OP_BYTE: begin
					idx_q <= '0;
					if (do_restart) begin
						fill_q <= FILL_W'(1);
					end else if (will_append && (fill_q < FILL_TIME)) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				OP_CHECK: begin
					if (done_t) begin
						hour_q <= ld_hour;
						minute_q <= ld_minute;
						second_q <= ld_second;
						valid_q <= 1'b1;
						fill_q <= '0;
					end else if (done_f) begin
						if (num_ok) begin
							alarm_hour_q[ent_sel] <= ent_hour;
							alarm_minute_q[ent_sel] <= ent_minute;
						end
						fill_q <= '0;
					end else if (done_c) begin
						if (num_ok) begin
							active_q <= CNT_W'(num);
						end
						fill_q <= '0;
					end
				end
				OP_MASK: begin
					idx_q <= '0;
				end
				OP_FEED, OP_ENTRY: begin
					if (!scan_end) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_ACCEPT) begin
			item_cmd_q <= cmd;
			item_byte_q <= rx_byte;
		end
		if (op == OP_BYTE) begin
			if (do_restart) begin
				buf_q[0] <= item_byte_q;
			end else if (will_append && (fill_q < FILL_TIME)) begin
				buf_q[fill_q] <= item_byte_q;
			end
		end
		if (op == OP_MASK) begin
			mask_q <= mask_d;
		end
		if (emit) begin
			kind_q <= e_kind;
			index_q <= e_index;
			hour_out_q <= e_hour;
			minute_out_q <= e_minute;
			second_out_q <= e_second;
			passed_q <= e_passed;
			last_q <= e_last;
		end
	end

	assign strobe         = strobe_q;
	assign kind           = kind_q;
	assign entry_index    = index_q;
	assign out_hour       = hour_out_q;
	assign out_minute     = minute_out_q;
	assign out_second     = second_out_q;
	assign already_passed = passed_q;
	assign last           = last_q;

endmodule

### test/tb_serial_scheduled_alarm_clock_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_scheduled_alarm_clock_unit: directed table, then random
// command traffic, each result checked against an in-bench prediction of the alarm clock.
// Depends on ssac_pkg and the RTL of serial_scheduled_alarm_clock_unit only.
module tb_serial_scheduled_alarm_clock_unit;
	import ssac_pkg::*;

	localparam int ENTRIES = ALARM_ENTRIES_DEFAULT;
	// The longest transaction walks the whole alarm table, and its last result leaves through a
	// register, so this many quiet cycles leave the block certainly idle.
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_LIMIT = 10;

	// One result of the block, field for field as it leaves the ports.
	typedef struct packed {
		kind_t      kind;
		logic [2:0] index;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
		logic       passed;
		logic       last;
	} clock_report_t;

	// One row of the directed table: the transaction, how often it is repeated, and where the
	// result is plain to see, the single result typed in by hand.
	typedef struct packed {
		logic          is_byte;
		logic [7:0]    value;
		logic [7:0]    reps;
		logic          typed;
		clock_report_t want;
	} plan_row_t;

	localparam clock_report_t NO_REPORT = '0;

	// The directed table runs with the reset rate of 20 ticks per second. It first checks that
	// an unset clock ignores ticks and every byte but T, that a second T restarts the command,
	// then sets 23:59:59 and rolls over midnight on the twentieth tick. With the default three
	// entries in use, the two spare entries at 00:00 must not fire. A manual feed, a count of
	// five, a full status report, a count of zero that must be refused and an entry set follow.
	localparam plan_row_t PLAN [28] = '{
		'{1'b0, 8'h00, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, CHAR_S_UPPER, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, 8'h00, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, CHAR_T_UPPER, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "2", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "3", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, CHAR_T_LOWER, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "2", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "3", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "5", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "9", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "5", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "9", 8'd1, 1'b1,
			'{KIND_TIME_SET, 3'd0, 8'd23, 8'd59, 8'd59, 1'b0, 1'b1}},
		'{1'b0, 8'hFF, 8'd19, 1'b0, NO_REPORT},
		'{1'b0, 8'h00, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, CHAR_M_UPPER, 8'd1, 1'b1,
			'{KIND_MANUAL_FEED, 3'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
		'{1'b1, 8'hFF, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, CHAR_C_UPPER, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "5", 8'd1, 1'b1,
			'{KIND_COUNT_SET, 3'd5, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
		'{1'b1, CHAR_S_UPPER, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, CHAR_C_LOWER, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "0", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, CHAR_F_LOWER, 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "1", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "0", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "0", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "0", 8'd1, 1'b0, NO_REPORT},
		'{1'b1, "1", 8'd1, 1'b1,
			'{KIND_ENTRY_SET, 3'd1, 8'd0, 8'd1, 8'd0, 1'b0, 1'b1}}
	};

	// Tick rates for the random phases: the extremes, zero (every tick is a second) and a few
	// small rates that let the clock reach whole minutes quickly.
	localparam int PHASES = 5;
	localparam logic [7:0] PHASE_RATE [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd1};
	localparam int PHASE_ITEMS = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       cmd = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       busy;
	logic       strobe;
	logic [2:0] kind;
	logic [2:0] entry_index;
	logic [7:0] out_hour;
	logic [7:0] out_minute;
	logic [7:0] out_second;
	logic       already_passed;
	logic       last;

	// Predicted state of the alarm clock, loaded with its reset values.
	logic [7:0] m_tps = TPS_RESET;
	logic [7:0] m_hour = '0;
	logic [7:0] m_min = '0;
	logic [7:0] m_sec = '0;
	logic [7:0] m_prescale = '0;
	logic       m_set = 1'b0;
	logic [7:0] m_buf [BUF_DEPTH];
	int         m_fill = 0;
	logic [7:0] m_ah [ENTRIES] = '{8'd8, 8'd13, 8'd20, 8'd0, 8'd0};
	logic [7:0] m_am [ENTRIES] = '{8'd0, 8'd30, 8'd0, 8'd0, 8'd0};
	logic [7:0] m_active = 8'(ACTIVE_RESET);

	clock_report_t step_events [$];
	clock_report_t due_events [$];
	int  errors = 0;
	int  sent = 0;
	bit  idle_on = 1'b1;

	serial_scheduled_alarm_clock_unit #(
		.ALARM_ENTRIES(ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.rx_byte(rx_byte),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.strobe(strobe),
		.kind(kind),
		.entry_index(entry_index),
		.out_hour(out_hour),
		.out_minute(out_minute),
		.out_second(out_second),
		.already_passed(already_passed),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The generous fixed limit on the whole run, well above the slowest correct run.
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic bit either_case(input logic [7:0] b, input logic [7:0] upper,
			input logic [7:0] lower);
		return b == upper || b == lower;
	endfunction

	// Two ASCII digits to a value; nothing is checked and the sum wraps at eight bits.
	function automatic logic [7:0] decimal_pair(input logic [7:0] tens, input logic [7:0] units);
		return 8'((tens - DIGIT_ZERO) * 8'd10 + (units - DIGIT_ZERO));
	endfunction

	function automatic int entries_in_use();
		return (int'(m_active) < ENTRIES) ? int'(m_active) : ENTRIES;
	endfunction

	function automatic void log_report(input kind_t k, input logic [2:0] idx,
			input logic [7:0] h, input logic [7:0] mi, input logic [7:0] s, input logic p);
		step_events.push_back('{k, idx, h, mi, s, p, 1'b0});
	endfunction

	function automatic void load_clock();
		m_hour = decimal_pair(m_buf[1], m_buf[2]);
		m_min = decimal_pair(m_buf[3], m_buf[4]);
		m_sec = decimal_pair(m_buf[5], m_buf[6]);
	endfunction

	// Advances the predicted clock by one accepted transaction and leaves the results that it
	// causes in step_events, the final one marked as last.
	function automatic void clock_step(input logic is_byte, input logic [7:0] b);
		logic [7:0] head;
		logic [7:0] num;
		logic       passed;
		step_events.delete();
		if (!is_byte) begin
			if (m_set) begin
				m_prescale = m_prescale + 8'd1;
				if (m_prescale >= m_tps) begin
					m_prescale = '0;
					m_sec = m_sec + 8'd1;
					if (m_sec >= SECONDS_PER_MINUTE) begin
						m_sec = '0;
						m_min = m_min + 8'd1;
						if (m_min >= MINUTES_PER_HOUR) begin
							m_min = '0;
							m_hour = m_hour + 8'd1;
							if (m_hour >= HOURS_PER_DAY)
								m_hour = '0;
						end
						for (int i = 0; i < entries_in_use(); i++)
							if (m_hour == m_ah[i] && m_min == m_am[i])
								log_report(KIND_AUTO_FEED, 3'(i + 1), m_hour, m_min, m_sec, 1'b0);
					end
				end
			end
		end else if (!m_set) begin
			// Before the clock is set only a T opens a command.
			if (either_case(b, CHAR_T_UPPER, CHAR_T_LOWER)) begin
				m_buf[0] = b;
				m_fill = 1;
			end else if (m_fill > 0) begin
				if (m_fill < BUF_DEPTH)
					m_buf[m_fill++] = b;
				if (m_fill >= BUF_DEPTH) begin
					load_clock();
					m_set = 1'b1;
					m_fill = 0;
					log_report(KIND_TIME_SET, 3'd0, m_hour, m_min, m_sec, 1'b0);
				end
			end
		end else if (either_case(b, CHAR_M_UPPER, CHAR_M_LOWER)) begin
			log_report(KIND_MANUAL_FEED, 3'd0, m_hour, m_min, m_sec, 1'b0);
		end else if (either_case(b, CHAR_S_UPPER, CHAR_S_LOWER)) begin
			log_report(KIND_STATUS_HEAD, m_active[2:0], m_hour, m_min, m_sec, 1'b0);
			for (int i = 0; i < entries_in_use(); i++) begin
				passed = m_hour > m_ah[i] || (m_hour == m_ah[i] && m_min >= m_am[i]);
				log_report(KIND_STATUS_ENTRY, 3'(i + 1), m_ah[i], m_am[i], 8'd0, passed);
			end
		end else if (either_case(b, CHAR_T_UPPER, CHAR_T_LOWER)
				|| either_case(b, CHAR_F_UPPER, CHAR_F_LOWER)
				|| either_case(b, CHAR_C_UPPER, CHAR_C_LOWER)) begin
			m_buf[0] = b;
			m_fill = 1;
		end else if (m_fill > 0) begin
			if (m_fill < BUF_DEPTH)
				m_buf[m_fill++] = b;
			head = m_buf[0];
			if (either_case(head, CHAR_T_UPPER, CHAR_T_LOWER) && m_fill >= int'(FILL_TIME)) begin
				load_clock();
				m_fill = 0;
				log_report(KIND_TIME_SET, 3'd0, m_hour, m_min, m_sec, 1'b0);
			end else if (either_case(head, CHAR_F_UPPER, CHAR_F_LOWER)
					&& m_fill == int'(FILL_ENTRY)) begin
				// An entry number outside the table closes the command silently.
				num = m_buf[1] - DIGIT_ZERO;
				if (num >= 8'd1 && int'(num) <= ENTRIES) begin
					m_ah[num - 1] = decimal_pair(m_buf[2], m_buf[3]);
					m_am[num - 1] = decimal_pair(m_buf[4], m_buf[5]);
					log_report(KIND_ENTRY_SET, num[2:0], m_ah[num - 1], m_am[num - 1], 8'd0, 1'b0);
				end
				m_fill = 0;
			end else if (either_case(head, CHAR_C_UPPER, CHAR_C_LOWER)
					&& m_fill == int'(FILL_COUNT)) begin
				num = m_buf[1] - DIGIT_ZERO;
				if (num >= 8'd1 && int'(num) <= ENTRIES) begin
					m_active = num;
					log_report(KIND_COUNT_SET, num[2:0], 8'd0, 8'd0, 8'd0, 1'b0);
				end
				m_fill = 0;
			end
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
	endfunction

	// Offers one transaction and holds it until the block takes it. The prediction is made at
	// the edge of acceptance; a typed row replaces the predicted results by its own. A random
	// burst of idle cycles may follow, with start lowered at the same edge.
	task automatic send(input logic is_byte, input logic [7:0] value,
			input logic typed = 1'b0, input clock_report_t want = '0);
		start <= 1'b1;
		cmd <= is_byte;
		rx_byte <= value;
		do @(posedge clk); while (busy);
		clock_step(is_byte, value);
		if (typed)
			due_events.push_back(want);
		else
			foreach (step_events[i])
				due_events.push_back(step_events[i]);
		sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Two decimal digits of a value, or now and then two arbitrary bytes in their place.
	task automatic send_value(input int v, input bit messy);
		if (messy) begin
			send(1'b1, 8'($urandom_range(0, 255)));
			send(1'b1, 8'($urandom_range(0, 255)));
		end else begin
			send(1'b1, DIGIT_ZERO + 8'(v / 10));
			send(1'b1, DIGIT_ZERO + 8'(v % 10));
		end
	endtask

	function automatic logic [7:0] any_case(input logic [7:0] upper, input logic [7:0] lower);
		return $urandom_range(0, 1) ? upper : lower;
	endfunction

	// The digit after F or C: mostly a valid number, sometimes any digit or any byte at all.
	function automatic logic [7:0] number_digit();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return DIGIT_ZERO + 8'($urandom_range(1, ENTRIES));
		else if (r == 8)
			return DIGIT_ZERO + 8'($urandom_range(0, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic settle();
		start <= 1'b0;
		while (due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_rate(input logic [7:0] rate);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= rate;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		m_tps = rate;
	endtask

	// Random traffic, mostly whole commands with random content. Setting the clock often aims
	// at the second before an alarm and, at small tick rates, follows up with enough ticks to
	// roll the minute, so that auto feeds come out, several at once where entries share a time.
	// The rest is broken commands, commands interrupted by M or S, stray bytes and loose ticks.
	task automatic random_phase(input int quota);
		int first, sel, k, h, mi, s;
		first = sent;
		while (sent - first < quota) begin
			sel = $urandom_range(0, 99);
			k = $urandom_range(0, entries_in_use() - 1);
			if (sel < 22) begin
				h = $urandom_range(0, 23);
				mi = $urandom_range(0, 59);
				s = $urandom_range(0, 59);
				if ($urandom_range(0, 9) < 6 && m_ah[k] < HOURS_PER_DAY
						&& m_am[k] < MINUTES_PER_HOUR) begin
					h = m_ah[k];
					mi = m_am[k];
					s = 59;
					if (mi == 0) begin
						mi = 59;
						h = (h == 0) ? 23 : h - 1;
					end else begin
						mi = mi - 1;
					end
				end
				send(1'b1, any_case(CHAR_T_UPPER, CHAR_T_LOWER));
				send_value(h, $urandom_range(0, 9) == 0);
				send_value(mi, $urandom_range(0, 9) == 0);
				send_value(s, $urandom_range(0, 9) == 0);
				if (m_tps <= 8'd3)
					repeat (int'(m_tps) + 1 + $urandom_range(0, 2))
						send(1'b0, 8'($urandom_range(0, 255)));
			end else if (sel < 40) begin
				repeat ($urandom_range(1, 5)) send(1'b0, 8'($urandom_range(0, 255)));
			end else if (sel < 55) begin
				h = $urandom_range(0, 23);
				mi = $urandom_range(0, 59);
				case ($urandom_range(0, 3))
					0: if (m_ah[k] < HOURS_PER_DAY && m_am[k] < MINUTES_PER_HOUR) begin
						h = m_ah[k];
						mi = m_am[k];
					end
					1: if (m_hour < HOURS_PER_DAY && m_min < MINUTES_PER_HOUR - 8'd1) begin
						h = m_hour;
						mi = m_min + 1;
					end
					default: ;
				endcase
				send(1'b1, any_case(CHAR_F_UPPER, CHAR_F_LOWER));
				send(1'b1, number_digit());
				send_value(h, $urandom_range(0, 9) == 0);
				send_value(mi, $urandom_range(0, 9) == 0);
			end else if (sel < 63) begin
				send(1'b1, any_case(CHAR_C_UPPER, CHAR_C_LOWER));
				send(1'b1, number_digit());
			end else if (sel < 78) begin
				if ($urandom_range(0, 1))
					send(1'b1, any_case(CHAR_M_UPPER, CHAR_M_LOWER));
				else
					send(1'b1, any_case(CHAR_S_UPPER, CHAR_S_LOWER));
			end else if (sel < 88) begin
				// A command cut short; M or S may interrupt it, later bytes may extend it.
				case ($urandom_range(0, 2))
					0: send(1'b1, any_case(CHAR_T_UPPER, CHAR_T_LOWER));
					1: send(1'b1, any_case(CHAR_F_UPPER, CHAR_F_LOWER));
					default: send(1'b1, any_case(CHAR_C_UPPER, CHAR_C_LOWER));
				endcase
				repeat ($urandom_range(0, 3)) send(1'b1, DIGIT_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 1))
					send(1'b1, $urandom_range(0, 1) ? any_case(CHAR_M_UPPER, CHAR_M_LOWER)
						: any_case(CHAR_S_UPPER, CHAR_S_LOWER));
			end else begin
				send(1'b1, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Results are taken at the edge that ends their cycle and matched against the oldest
	// expectation. Outputs are read before the edge updates them, so there is no race here.
	always @(posedge clk) begin
		clock_report_t want;
		if (arst_n && strobe) begin
			if (due_events.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result: kind %0d index %0d %0d:%0d:%0d passed %0d last %0d",
						kind, entry_index, out_hour, out_minute, out_second, already_passed, last);
			end else begin
				want = due_events.pop_front();
				if (kind !== want.kind || entry_index !== want.index || out_hour !== want.hour
						|| out_minute !== want.minute || out_second !== want.second
						|| already_passed !== want.passed || last !== want.last) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("mismatch: expected kind %0d index %0d %0d:%0d:%0d passed %0d last %0d, got kind %0d index %0d %0d:%0d:%0d passed %0d last %0d",
							want.kind, want.index, want.hour, want.minute, want.second,
							want.passed, want.last, kind, entry_index, out_hour, out_minute,
							out_second, already_passed, last);
				end
			end
		end
	end

	// Reset once, walk the directed table at the reset rate, then run one random phase per
	// tick rate. The rate is only rewritten once the block has gone quiet, and the final
	// phase runs without any idle cycles between transactions.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (PLAN[r])
			repeat (PLAN[r].reps)
				send(PLAN[r].is_byte, PLAN[r].value, PLAN[r].typed, PLAN[r].want);
		settle();
		for (int p = 0; p < PHASES; p++) begin
			write_tick_rate(PHASE_RATE[p]);
			idle_on = (p < PHASES - 1);
			random_phase(PHASE_ITEMS);
			settle();
		end
		if (errors == 0 && due_events.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
